### hw/rtl/ftsc_pkg.sv
// Package for the flow table statistics core.
// Holds sizes, codes, shared structs and saturating adders.
// No dependencies.
package ftsc_pkg;

	localparam int FLOW_SLOTS = 64;
	localparam int SLOT_W     = $clog2(FLOW_SLOTS);
	localparam int PROTO_BINS = 256;
	localparam int BIN_W      = $clog2(PROTO_BINS);
	localparam int PKT_W      = 32;
	localparam int BYTE_W     = 48;
	localparam int TS_W       = 48;
	localparam int OUT_SLOT_W = 6;

	localparam logic [1:0] ACT_INGEST  = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	localparam logic [1:0] CONN_NEW   = 2'd0;
	localparam logic [1:0] CONN_EST   = 2'd1;
	localparam logic [1:0] CONN_CLOSE = 2'd2;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] FLAG_SYN  = 8'h02;
	localparam logic [7:0] FLAG_ACK  = 8'h10;
	localparam logic [7:0] FLAG_FIN  = 8'h01;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_UPD
	} fsm_t;

	typedef struct packed {
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;
		logic [15:0] iface_proto;
	} flow_key_t;

	typedef struct packed {
		logic              look;
		logic              upd;
		logic              clr;
		logic              c2s;
		logic [7:0]        proto;
		logic [7:0]        flags;
		logic [15:0]       len;
		logic [TS_W-1:0]   ts;
	} cell_ctl_t;

	typedef struct packed {
		logic              hit;
		logic              free;
		logic              found;
		logic              newf;
		logic [SLOT_W-1:0] slot;
		logic [PKT_W-1:0]  pkts;
		logic [BYTE_W-1:0] bytes;
		logic [TS_W-1:0]   first;
		logic [1:0]        st;
	} chain_t;

	function automatic logic [PKT_W-1:0] inc_sat(input logic [PKT_W-1:0] a);
		return (&a) ? a : a + 1'b1;
	endfunction

	function automatic logic [BYTE_W-1:0] add_sat(input logic [BYTE_W-1:0] a,
		input logic [15:0] b);
		logic [BYTE_W:0] s;
		s = {1'b0, a} + {{(BYTE_W-15){1'b0}}, b};
		return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
	endfunction

endpackage

### hw/rtl/ftsc_cell.sv
// One flow table slot: key, counters and connection state.
// Hands hit/free and the selected slot's results along the chain.
// Depends on ftsc_pkg.
module ftsc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ftsc_pkg::cell_ctl_t        ctl,
	input  ftsc_pkg::flow_key_t        key,
	input  logic [ftsc_pkg::SLOT_W-1:0] idx,
	input  logic                       any_hit,
	input  ftsc_pkg::chain_t           chain_in,
	output ftsc_pkg::chain_t           chain_out
);
	logic                             valid_q, match_q;
	ftsc_pkg::flow_key_t              key_q;
	logic [ftsc_pkg::PKT_W-1:0]       fwd_p_q, rev_p_q;
	logic [ftsc_pkg::BYTE_W-1:0]      fwd_b_q, rev_b_q;
	logic [ftsc_pkg::TS_W-1:0]        first_q;
	logic [1:0]                       st_q;
	logic                             sel_hit, sel_new, sel;
	logic [ftsc_pkg::PKT_W-1:0]       p_base, p_new;
	logic [ftsc_pkg::BYTE_W-1:0]      b_base, b_new;
	logic [ftsc_pkg::TS_W-1:0]        first_n;
	logic [1:0]                       st_base, st_n;

	always_comb begin
		sel_hit = match_q & ~chain_in.hit;
		sel_new = ~valid_q & ~chain_in.free & ~any_hit;
		sel     = sel_hit | sel_new;
		p_base  = sel_new ? '0 : (ctl.c2s ? fwd_p_q : rev_p_q);
		b_base  = sel_new ? '0 : (ctl.c2s ? fwd_b_q : rev_b_q);
		p_new   = ftsc_pkg::inc_sat(p_base);
		b_new   = ftsc_pkg::add_sat(b_base, ctl.len);
		first_n = sel_new ? ctl.ts : first_q;
		st_base = sel_new ? ftsc_pkg::CONN_NEW : st_q;
		st_n    = st_base;
		if (ctl.proto == ftsc_pkg::PROTO_TCP) begin
			if ((ctl.flags & ftsc_pkg::FLAG_SYN) != 8'd0)
				st_n = ftsc_pkg::CONN_NEW;
			else if ((ctl.flags & ftsc_pkg::FLAG_ACK) != 8'd0) begin
				if (st_base == ftsc_pkg::CONN_NEW)
					st_n = ftsc_pkg::CONN_EST;
			end else if ((ctl.flags & ftsc_pkg::FLAG_FIN) != 8'd0)
				st_n = ftsc_pkg::CONN_CLOSE;
		end else if (st_base == ftsc_pkg::CONN_NEW) begin
			st_n = ftsc_pkg::CONN_EST;
		end
		chain_out       = chain_in;
		chain_out.hit   = chain_in.hit | match_q;
		chain_out.free  = chain_in.free | ~valid_q;
		if (sel) begin
			chain_out.found = 1'b1;
			chain_out.newf  = sel_new;
			chain_out.slot  = idx;
			chain_out.pkts  = p_new;
			chain_out.bytes = b_new;
			chain_out.first = first_n;
			chain_out.st    = st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.look)
				match_q <= valid_q && (key_q == key);
			if (ctl.clr)
				valid_q <= 1'b0;
			else if (ctl.upd && sel_new)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && sel) begin
			if (sel_new)
				key_q <= key;
			if (ctl.c2s) begin
				fwd_p_q <= p_new;
				fwd_b_q <= b_new;
				if (sel_new) begin
					rev_p_q <= '0;
					rev_b_q <= '0;
				end
			end else begin
				rev_p_q <= p_new;
				rev_b_q <= b_new;
				if (sel_new) begin
					fwd_p_q <= '0;
					fwd_b_q <= '0;
				end
			end
			first_q <= first_n;
			st_q    <= st_n;
		end
	end
endmodule

### hw/rtl/flow_table_statistics_core.sv
// Top level of the flow table statistics core.
// Depends on ftsc_pkg and ftsc_cell.
//
// Usage: drive a word on the input ports with start high while busy is low;
// it is taken at that edge. Action 0 looks up and updates the flow table and
// adds the packet to its protocol bin and the window totals, action 1 reports
// and clears the window, action 2 reads one protocol bin. Every word gives
// exactly one result, shown for one cycle with done high. After the accepting
// edge the word passes the lookup and update states, busy high in both, and
// done is registered from the update state. A new word may be started in the
// cycle that shows done, not before. Lookup holds the registered key compare in
// the slot chain and the registered read of the protocol bin memory; update
// holds the chain select and counter update.
// The flow table is a chain of 64 slot cells; protocol bins live in a
// 256-entry memory with one valid flip-flop per entry.
// Reset clears the slot valid bits, bin valid bits, window totals and
// window count at once; the block is idle and ready once reset is released.
// The receiver cannot stall: each result must be taken while done is high.
module flow_table_statistics_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   action,
	input  logic [7:0]   iface_id,
	input  logic [7:0]   protocol,
	input  logic [63:0]  src_addr_hi,
	input  logic [63:0]  src_addr_lo,
	input  logic [63:0]  dst_addr_hi,
	input  logic [63:0]  dst_addr_lo,
	input  logic [15:0]  l4_src,
	input  logic [15:0]  l4_dst,
	input  logic [7:0]   tcp_flag_bits,
	input  logic [15:0]  captured_length,
	input  logic [47:0]  timestamp,
	output logic         done,
	output logic         status,
	output logic [5:0]   flow_slot,
	output logic         new_flow,
	output logic         client_to_server,
	output logic [1:0]   flow_state,
	output logic [31:0]  packet_count,
	output logic [47:0]  byte_count,
	output logic [47:0]  flow_start,
	output logic [31:0]  window_number
);
	localparam int BIN_DW = ftsc_pkg::PKT_W + ftsc_pkg::BYTE_W;

	ftsc_pkg::fsm_t                   state_q, state_n;
	ftsc_pkg::flow_key_t              key_q;
	ftsc_pkg::cell_ctl_t              ctl;
	ftsc_pkg::chain_t                 chain [ftsc_pkg::FLOW_SLOTS+1];
	logic [1:0]                       act_q;
	logic [7:0]                       flags_q;
	logic [15:0]                      len_q;
	logic [ftsc_pkg::TS_W-1:0]        ts_q;
	logic                             c2s_q;
	logic                             any_hit;
	logic [BIN_DW-1:0]                bin_mem [ftsc_pkg::PROTO_BINS];
	logic [BIN_DW-1:0]                bin_rd_q;
	logic                             bin_rdv_q;
	logic [ftsc_pkg::PROTO_BINS-1:0]  bin_vld_q;
	logic [ftsc_pkg::PKT_W-1:0]       bin_p, win_p_q, wc_q, wc_n;
	logic [ftsc_pkg::BYTE_W-1:0]      bin_b, win_b_q;
	logic                             c2s_n;
	logic                             do_ing, do_adv;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ftsc_pkg::S_IDLE: if (start) state_n = ftsc_pkg::S_LOOK;
			ftsc_pkg::S_LOOK: state_n = ftsc_pkg::S_UPD;
			ftsc_pkg::S_UPD:  state_n = ftsc_pkg::S_IDLE;
			default:          state_n = ftsc_pkg::S_IDLE;
		endcase
	end

	assign busy   = (state_q != ftsc_pkg::S_IDLE);
	assign do_ing = (state_q == ftsc_pkg::S_UPD) && (act_q == ftsc_pkg::ACT_INGEST);
	assign do_adv = (state_q == ftsc_pkg::S_UPD) && (act_q == ftsc_pkg::ACT_ADVANCE);

	always_comb begin
		if (key_q.src_hi != key_q.dst_hi)
			c2s_n = key_q.src_hi < key_q.dst_hi;
		else if (key_q.src_lo != key_q.dst_lo)
			c2s_n = key_q.src_lo < key_q.dst_lo;
		else
			c2s_n = key_q.ports[31:16] <= key_q.ports[15:0];
	end

	always_comb begin
		ctl.look  = (state_q == ftsc_pkg::S_LOOK);
		ctl.upd   = do_ing;
		ctl.clr   = do_adv;
		ctl.c2s   = c2s_q;
		ctl.proto = key_q.iface_proto[7:0];
		ctl.flags = flags_q;
		ctl.len   = len_q;
		ctl.ts    = ts_q;
	end

	assign chain[0] = '0;
	assign any_hit  = chain[ftsc_pkg::FLOW_SLOTS].hit;

	for (genvar g = 0; g < ftsc_pkg::FLOW_SLOTS; g++) begin : g_cell
		ftsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key_q),
			.idx      (ftsc_pkg::SLOT_W'(g)),
			.any_hit  (any_hit),
			.chain_in (chain[g]),
			.chain_out(chain[g+1])
		);
	end

	assign bin_p = bin_rdv_q ? bin_rd_q[BIN_DW-1:ftsc_pkg::BYTE_W] : '0;
	assign bin_b = bin_rdv_q ? bin_rd_q[ftsc_pkg::BYTE_W-1:0] : '0;
	assign wc_n  = do_adv ? ftsc_pkg::inc_sat(wc_q) : wc_q;

	always_ff @(posedge clk) begin
		if (state_q == ftsc_pkg::S_IDLE && start) begin
			act_q   <= action;
			key_q   <= '{src_hi: src_addr_hi, src_lo: src_addr_lo,
				dst_hi: dst_addr_hi, dst_lo: dst_addr_lo,
				ports: {l4_src, l4_dst}, iface_proto: {iface_id, protocol}};
			flags_q <= tcp_flag_bits;
			len_q   <= captured_length;
			ts_q    <= timestamp;
		end
		if (state_q == ftsc_pkg::S_LOOK) begin
			c2s_q    <= c2s_n;
			bin_rd_q <= bin_mem[key_q.iface_proto[ftsc_pkg::BIN_W-1:0]];
		end
		if (do_ing)
			bin_mem[key_q.iface_proto[ftsc_pkg::BIN_W-1:0]] <=
				{ftsc_pkg::inc_sat(bin_p), ftsc_pkg::add_sat(bin_b, len_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ftsc_pkg::S_IDLE;
			bin_vld_q <= '0;
			bin_rdv_q <= 1'b0;
			win_p_q   <= '0;
			win_b_q   <= '0;
			wc_q      <= '0;
			done      <= 1'b0;
		end else begin
			state_q <= state_n;
			done    <= (state_q == ftsc_pkg::S_UPD);
			if (state_q == ftsc_pkg::S_LOOK)
				bin_rdv_q <= bin_vld_q[key_q.iface_proto[ftsc_pkg::BIN_W-1:0]];
			if (do_adv) begin
				bin_vld_q <= '0;
				win_p_q   <= '0;
				win_b_q   <= '0;
			end else if (do_ing) begin
				bin_vld_q[key_q.iface_proto[ftsc_pkg::BIN_W-1:0]] <= 1'b1;
				win_p_q <= ftsc_pkg::inc_sat(win_p_q);
				win_b_q <= ftsc_pkg::add_sat(win_b_q, len_q);
			end
			wc_q <= wc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ftsc_pkg::S_UPD) begin
			status           <= 1'b0;
			flow_slot        <= '0;
			new_flow         <= 1'b0;
			client_to_server <= 1'b0;
			flow_state       <= ftsc_pkg::CONN_NEW;
			packet_count     <= '0;
			byte_count       <= '0;
			flow_start       <= '0;
			window_number    <= wc_n;
			case (act_q)
				ftsc_pkg::ACT_INGEST: begin
					client_to_server <= c2s_q;
					if (!chain[ftsc_pkg::FLOW_SLOTS].found) begin
						status <= 1'b1;
					end else begin
						flow_slot    <= ftsc_pkg::OUT_SLOT_W'(chain[ftsc_pkg::FLOW_SLOTS].slot);
						new_flow     <= chain[ftsc_pkg::FLOW_SLOTS].newf;
						flow_state   <= chain[ftsc_pkg::FLOW_SLOTS].st;
						packet_count <= chain[ftsc_pkg::FLOW_SLOTS].pkts;
						byte_count   <= chain[ftsc_pkg::FLOW_SLOTS].bytes;
						flow_start   <= chain[ftsc_pkg::FLOW_SLOTS].first;
					end
				end
				ftsc_pkg::ACT_ADVANCE: begin
					packet_count <= win_p_q;
					byte_count   <= win_b_q;
				end
				ftsc_pkg::ACT_READ: begin
					packet_count <= bin_p;
					byte_count   <= bin_b;
				end
				default: ;
			endcase
		end
	end
endmodule

### hw/rtl/ftsc_checker.sv
// Port-level checks for the flow table statistics core.
// Depends on flow_table_statistics_core; bound to it below.
module ftsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       status,
	input logic [5:0] flow_slot,
	input logic       new_flow
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ##2 done) else $error("result not delivered on time");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> flow_slot == 6'd0 && !new_flow)
		else $error("table full result carries a slot");
endmodule

bind flow_table_statistics_core ftsc_checker u_ftsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.flow_slot(flow_slot),
	.new_flow (new_flow)
);

### sim/testbench.sv
// Testbench for flow_table_statistics_core: directed and random words checked
// against a scoreboard that models the flow table, protocol bins and window.
// Depends on ftsc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [1:0]  action;
		logic [7:0]  iface;
		logic [7:0]  proto;
		logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
		logic [15:0] sport, dport;
		logic [7:0]  flags;
		logic [15:0] len;
		logic [47:0] ts;
	} word_t;

	typedef struct {
		logic        status;
		logic [5:0]  slot;
		logic        newf;
		logic        c2s;
		logic [1:0]  st;
		logic [31:0] pkts;
		logic [47:0] bytes;
		logic [47:0] first;
		logic [31:0] win;
	} res_t;

	class flow_scoreboard;
		bit          valid [ftsc_pkg::FLOW_SLOTS];
		word_t       key [ftsc_pkg::FLOW_SLOTS];
		logic [31:0] fwd_p [ftsc_pkg::FLOW_SLOTS], rev_p [ftsc_pkg::FLOW_SLOTS];
		logic [47:0] fwd_b [ftsc_pkg::FLOW_SLOTS], rev_b [ftsc_pkg::FLOW_SLOTS];
		logic [47:0] first [ftsc_pkg::FLOW_SLOTS];
		logic [1:0]  conn [ftsc_pkg::FLOW_SLOTS];
		logic [31:0] bin_p [ftsc_pkg::PROTO_BINS];
		logic [47:0] bin_b [ftsc_pkg::PROTO_BINS];
		logic [31:0] win_p, closed;
		logic [47:0] win_b;
		res_t        pending[$];
		int          failures;

		function new();
			clear_window();
			closed = 0;
			failures = 0;
		endfunction

		function void clear_window();
			foreach (valid[i]) valid[i] = 0;
			foreach (bin_p[i]) begin
				bin_p[i] = 0;
				bin_b[i] = 0;
			end
			win_p = 0;
			win_b = 0;
		endfunction

		function logic [31:0] bump(logic [31:0] a);
			return (&a) ? a : a + 32'd1;
		endfunction

		function logic [47:0] grow(logic [47:0] a, logic [15:0] b);
			logic [48:0] s;
			s = {1'b0, a} + {33'd0, b};
			return s[48] ? {48{1'b1}} : s[47:0];
		endfunction

		function bit same_key(word_t a, word_t b);
			return a.src_hi == b.src_hi && a.src_lo == b.src_lo && a.dst_hi == b.dst_hi
				&& a.dst_lo == b.dst_lo && a.sport == b.sport && a.dport == b.dport
				&& a.iface == b.iface && a.proto == b.proto;
		endfunction

		function void note_word(word_t w);
			res_t r;
			int hit, free_slot, s;
			logic [1:0] st;
			r = '{default: '0};
			case (w.action)
				ftsc_pkg::ACT_INGEST: begin
					hit = -1;
					free_slot = -1;
					if (w.src_hi != w.dst_hi) r.c2s = w.src_hi < w.dst_hi;
					else if (w.src_lo != w.dst_lo) r.c2s = w.src_lo < w.dst_lo;
					else r.c2s = w.sport <= w.dport;
					for (int i = 0; i < ftsc_pkg::FLOW_SLOTS; i++) begin
						if (valid[i]) begin
							if (hit < 0 && same_key(key[i], w)) hit = i;
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					bin_b[w.proto] = grow(bin_b[w.proto], w.len);
					bin_p[w.proto] = bump(bin_p[w.proto]);
					win_b = grow(win_b, w.len);
					win_p = bump(win_p);
					if (hit < 0 && free_slot < 0) begin
						r.status = 1;
					end else begin
						s = hit;
						if (s < 0) begin
							s = free_slot;
							valid[s] = 1;
							key[s] = w;
							fwd_p[s] = 0;
							rev_p[s] = 0;
							fwd_b[s] = 0;
							rev_b[s] = 0;
							first[s] = w.ts;
							conn[s] = ftsc_pkg::CONN_NEW;
							r.newf = 1;
						end
						if (r.c2s) begin
							fwd_b[s] = grow(fwd_b[s], w.len);
							fwd_p[s] = bump(fwd_p[s]);
							r.pkts = fwd_p[s];
							r.bytes = fwd_b[s];
						end else begin
							rev_b[s] = grow(rev_b[s], w.len);
							rev_p[s] = bump(rev_p[s]);
							r.pkts = rev_p[s];
							r.bytes = rev_b[s];
						end
						st = conn[s];
						if (w.proto == ftsc_pkg::PROTO_TCP) begin
							if ((w.flags & ftsc_pkg::FLAG_SYN) != 0) st = ftsc_pkg::CONN_NEW;
							else if ((w.flags & ftsc_pkg::FLAG_ACK) != 0) begin
								if (st == ftsc_pkg::CONN_NEW) st = ftsc_pkg::CONN_EST;
							end else if ((w.flags & ftsc_pkg::FLAG_FIN) != 0)
								st = ftsc_pkg::CONN_CLOSE;
						end else if (st == ftsc_pkg::CONN_NEW) begin
							st = ftsc_pkg::CONN_EST;
						end
						conn[s] = st;
						r.slot = s[5:0];
						r.st = st;
						r.first = first[s];
					end
				end
				ftsc_pkg::ACT_ADVANCE: begin
					closed = bump(closed);
					r.pkts = win_p;
					r.bytes = win_b;
					clear_window();
				end
				ftsc_pkg::ACT_READ: begin
					r.pkts = bin_p[w.proto];
					r.bytes = bin_b[w.proto];
				end
				default: ;
			endcase
			r.win = closed;
			pending = {pending, r};
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (a !== e) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				failures++;
			end
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending");
				failures++;
				return;
			end
			e = pending.pop_front();
			cmp("status", 64'(e.status), 64'(a.status));
			cmp("flow_slot", 64'(e.slot), 64'(a.slot));
			cmp("new_flow", 64'(e.newf), 64'(a.newf));
			cmp("client_to_server", 64'(e.c2s), 64'(a.c2s));
			cmp("flow_state", 64'(e.st), 64'(a.st));
			cmp("packet_count", 64'(e.pkts), 64'(a.pkts));
			cmp("byte_count", 64'(e.bytes), 64'(a.bytes));
			cmp("flow_start", 64'(e.first), 64'(a.first));
			cmp("window_number", 64'(e.win), 64'(a.win));
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, done;
	logic [1:0] action = 0;
	logic [7:0] iface_id = 0, protocol = 0, tcp_flag_bits = 0;
	logic [63:0] src_addr_hi = 0, src_addr_lo = 0, dst_addr_hi = 0, dst_addr_lo = 0;
	logic [15:0] l4_src = 0, l4_dst = 0, captured_length = 0;
	logic [47:0] timestamp = 0;
	logic status, new_flow, client_to_server;
	logic [5:0] flow_slot;
	logic [1:0] flow_state;
	logic [31:0] packet_count, window_number;
	logic [47:0] byte_count, flow_start;

	flow_scoreboard sb = new();
	word_t flows[$];
	logic [47:0] now_ts = 0;
	int idle_pct = 0;
	int quiet = 0;

	flow_table_statistics_core u_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(res_t'{status, flow_slot, new_flow, client_to_server,
					flow_state, packet_count, byte_count, flow_start, window_number});
			if (start && !busy)
				sb.note_word(word_t'{action, iface_id, protocol, src_addr_hi, src_addr_lo,
					dst_addr_hi, dst_addr_lo, l4_src, l4_dst, tcp_flag_bits,
					captured_length, timestamp});
			if (done || (start && !busy))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("FAIL flow_table_statistics_core");
				$finish;
			end
		end
	end

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task send_word(word_t w);
		action <= w.action;
		iface_id <= w.iface;
		protocol <= w.proto;
		src_addr_hi <= w.src_hi;
		src_addr_lo <= w.src_lo;
		dst_addr_hi <= w.dst_hi;
		dst_addr_lo <= w.dst_lo;
		l4_src <= w.sport;
		l4_dst <= w.dport;
		tcp_flag_bits <= w.flags;
		captured_length <= w.len;
		timestamp <= w.ts;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function word_t make_flow();
		word_t w;
		w = '{default: '0};
		w.iface = 8'($urandom);
		case ($urandom_range(3))
			0: w.proto = 8'($urandom);
			1: w.proto = 8'd17;
			default: w.proto = ftsc_pkg::PROTO_TCP;
		endcase
		case ($urandom_range(3))
			0: begin
				w.src_lo = 64'($urandom);
				w.dst_lo = 64'($urandom);
			end
			1: begin
				w.src_hi = rand64();
				w.dst_hi = w.src_hi;
				w.src_lo = rand64();
				w.dst_lo = $urandom_range(1) ? w.src_lo : rand64();
			end
			default: begin
				w.src_hi = rand64();
				w.src_lo = rand64();
				w.dst_hi = rand64();
				w.dst_lo = rand64();
			end
		endcase
		w.sport = 16'($urandom);
		w.dport = $urandom_range(3) == 0 ? w.sport : 16'($urandom);
		return w;
	endfunction

	function word_t packet_of(word_t f);
		word_t w;
		w = f;
		if ($urandom_range(3) == 0) begin
			w.src_hi = f.dst_hi;
			w.src_lo = f.dst_lo;
			w.dst_hi = f.src_hi;
			w.dst_lo = f.src_lo;
			w.sport = f.dport;
			w.dport = f.sport;
		end
		w.action = ftsc_pkg::ACT_INGEST;
		case ($urandom_range(5))
			0: w.flags = ftsc_pkg::FLAG_SYN;
			1: w.flags = ftsc_pkg::FLAG_ACK;
			2: w.flags = ftsc_pkg::FLAG_FIN;
			3: w.flags = 8'd0;
			default: w.flags = 8'($urandom);
		endcase
		w.len = $urandom_range(7) == 0 ? 16'hffff : 16'($urandom);
		now_ts = now_ts + 48'($urandom_range(1, 1000));
		w.ts = $urandom_range(15) == 0 ? 48'(rand64()) : now_ts;
		return w;
	endfunction

	function word_t random_word();
		word_t w;
		int pick;
		pick = $urandom_range(199);
		if (pick < 2) begin
			w = packet_of(make_flow());
			w.action = ftsc_pkg::ACT_ADVANCE;
		end else if (pick < 14) begin
			w = packet_of(make_flow());
			w.action = ftsc_pkg::ACT_READ;
			if (pick < 9) w.proto = flows[$urandom_range(flows.size() - 1)].proto;
		end else if (pick < 17) begin
			w = packet_of(make_flow());
			w.action = ACT_UNUSED;
		end else if (pick < 30) begin
			w = packet_of(make_flow());
		end else begin
			w = packet_of(flows[$urandom_range(flows.size() - 1)]);
		end
		return w;
	endfunction

	initial begin
		word_t w, base;
		int phase_pct [4] = '{0, 55, 20, 0};
		logic [7:0] flag_seq [9] = '{ftsc_pkg::FLAG_SYN, ftsc_pkg::FLAG_ACK, 8'h13,
			ftsc_pkg::FLAG_FIN, 8'h11, 8'h00, ftsc_pkg::FLAG_SYN, ftsc_pkg::FLAG_FIN,
			ftsc_pkg::FLAG_ACK};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every action, flag priorities
		base = '{default: '0};
		send_word(base);
		w = '{default: '1};
		w.action = ftsc_pkg::ACT_INGEST;
		send_word(w);
		send_word(w);
		w = base;
		w.proto = ftsc_pkg::PROTO_TCP;
		w.src_hi = 5;
		w.dst_hi = 5;
		w.src_lo = 9;
		w.dst_lo = 9;
		w.sport = 80;
		w.dport = 80;
		w.len = 100;
		foreach (flag_seq[i]) begin
			w.flags = flag_seq[i];
			w.ts = 48'(100 + i);
			send_word(w);
		end
		w.sport = 81;
		send_word(w);
		w.proto = 8'd17;
		send_word(w);
		w.action = ftsc_pkg::ACT_READ;
		send_word(w);
		w.proto = ftsc_pkg::PROTO_TCP;
		send_word(w);
		w.proto = 8'hff;
		send_word(w);
		w.action = ACT_UNUSED;
		send_word(w);
		w.action = ftsc_pkg::ACT_ADVANCE;
		send_word(w);
		w.action = ftsc_pkg::ACT_READ;
		w.proto = ftsc_pkg::PROTO_TCP;
		send_word(w);

		for (int i = 0; i < 96; i++) flows = {flows, make_flow()};
		foreach (phase_pct[p]) begin
			idle_pct = phase_pct[p];
			repeat (340) send_word(random_word());
		end
		start <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("PASS flow_table_statistics_core");
		else
			$display("FAIL flow_table_statistics_core");
		$finish;
	end

endmodule
